// ===== rtl/windowed_trade_rate_spike_monitor_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the trade-rate spike monitor
// Shared helpers, clocked on clk_i and held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_TRADE_RATE_SPIKE_MONITOR_TOP_DEFINES_SVH
`define WINDOWED_TRADE_RATE_SPIKE_MONITOR_TOP_DEFINES_SVH

// A property that must hold at every clock edge out of reset.
`define WTRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// A condition that must never be seen at a clock edge out of reset.
`define WTRS_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/wtrs_pkg.sv =====
// ----------------------------------------------------------------------------
// Trade-rate spike monitor package
// Types, codes and constants shared by the monitor's modules.
// ----------------------------------------------------------------------------
`default_nettype none

package wtrs_pkg;

  localparam int HISTORY_DEPTH_DEF = 256;
  localparam int TIME_W = 40;
  localparam int VOL_W  = 16;

  // Records older than fifteen minutes are retired.
  localparam logic [TIME_W-1:0] MAX_AGE_MS = 40'd900000;

  // Sixty seconds times 256 for the Q8 rate.
  localparam int RATE_SCALE = 15360;

  localparam logic [5:0]  BASELINE_RST = 6'd3;
  localparam logic [8:0]  SHORT_RST    = 9'd30;
  localparam logic [15:0] MULT_RST     = 16'd512;
  localparam logic [15:0] MIN_SIZE_RST = 16'd1;

  localparam logic [1:0] KIND_ASK_LIFT = 2'd0;
  localparam logic [1:0] KIND_BID_HIT  = 2'd1;

  localparam logic [1:0] SIDE_ASK = 2'b01;
  localparam logic [1:0] SIDE_BID = 2'b11;

  typedef enum logic [1:0] {
    CFG_BASELINE = 2'd0,
    CFG_SHORT    = 2'd1,
    CFG_MULT     = 2'd2,
    CFG_MIN_SIZE = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RETIRE,
    S_STORE,
    S_SCAN,
    S_MUL1,
    S_MUL2,
    S_DIVB,
    S_WAITB,
    S_DIVS,
    S_WAITS,
    S_DIVA,
    S_WAITA,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [TIME_W-1:0] t;
    logic [VOL_W-1:0]  v;
  } rec_t;

endpackage

`default_nettype wire

// ===== rtl/wtrs_cell.sv =====
// ----------------------------------------------------------------------------
// History cell
// One stored trade record; hands it to the next cell on every shift.
// ----------------------------------------------------------------------------
`default_nettype none

module wtrs_cell (
  input  wire logic          clk_i,
  input  wire logic          shift_i,
  input  wire wtrs_pkg::rec_t rec_i,
  output wtrs_pkg::rec_t      rec_o
);
  import wtrs_pkg::*;

  rec_t rec_q;

  // The record moves along the chain whenever the chain shifts.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      rec_q <= rec_i;
    end
  end

  assign rec_o = rec_q;

endmodule

`default_nettype wire

// ===== rtl/wtrs_div.sv =====
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wtrs_div #(
  parameter int NUM_W = 33,
  parameter int DEN_W = 12
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  busy_o,
  output logic                  done_o,
  output logic [NUM_W-1:0]      quo_o
);
  import wtrs_pkg::*;

  localparam int CW = $clog2(NUM_W + 1);

  logic [CW-1:0]    cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W:0]   rem_sh;

  // One shift-and-subtract step per cycle.
  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    rem_sh = {rem_q, quo_q[NUM_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      den_d  = den_i;
      quo_d  = num_i;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = DEN_W'(rem_sh - {1'b0, den_q});
        quo_d = {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DEN_W-1:0];
        quo_d = {quo_q[NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

// ===== rtl/windowed_trade_rate_spike_monitor_top.sv =====
// ----------------------------------------------------------------------------
// Windowed trade-rate spike monitor
// Keeps a rotating history of trades and reports windowed rates per trade.
// ----------------------------------------------------------------------------
// Each accepted trade first retires the records that have grown too old, at most
// D of them, where D is HISTORY_DEPTH. The history is a rotating chain of cells
// read at its far end, so retiring walks one record a cycle and the window scan
// takes one full turn of the chain. The three quotients come one bit a cycle
// from a shared divider. A full history adds a store step that overwrites its
// oldest record, and an empty short window skips the mean-size quotient. A trade
// that is done waits while the result side holds back an earlier beat.
// Dropped prints (quotes, other kinds, stale sequence numbers, small trades)
// are taken and give no result beat. A result beat waits in the output register
// while the next trade is taken.
`default_nettype none

module windowed_trade_rate_spike_monitor_top #(
  parameter int HISTORY_DEPTH = wtrs_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // sequence_number, trade_time_ms, now_time_ms, price_ticks, trade_volume
  input  wire logic [159:0] s_axis_tdata,
  // print_kind
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // out_price_ticks, out_volume, short_window_count, avg_size_q8,
  // rate_baseline_q8, rate_short_q8, spike_alert, zero padding
  output logic [127:0]      m_axis_tdata,
  // trade_side
  output logic [1:0]        m_axis_tuser,
  input  wire logic         cfg_we_i,
  input  wire logic [1:0]   cfg_idx_i,
  input  wire logic [15:0]  cfg_data_i
);
  import wtrs_pkg::*;

  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int NUM_W = CNT_W + 24;
  localparam int DEN_W = (CNT_W > 12) ? CNT_W : 12;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(HISTORY_DEPTH);
  localparam logic [CNT_W-1:0] LAST_K  = CNT_W'(HISTORY_DEPTH - 1);

  // Configuration registers.
  logic [5:0]  base_min_q;
  logic [8:0]  short_sec_q;
  logic [15:0] mult_q;
  logic [15:0] min_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_min_q  <= BASELINE_RST;
      short_sec_q <= SHORT_RST;
      mult_q      <= MULT_RST;
      min_size_q  <= MIN_SIZE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_BASELINE: base_min_q  <= cfg_data_i[5:0];
        CFG_SHORT:    short_sec_q <= cfg_data_i[8:0];
        CFG_MULT:     mult_q      <= cfg_data_i;
        CFG_MIN_SIZE: min_size_q  <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  // Input beat fields.
  logic [1:0]        in_kind;
  logic [31:0]       in_seq;
  logic [TIME_W-1:0] in_ttime;
  logic [TIME_W-1:0] in_now;
  logic [31:0]       in_price;
  logic [VOL_W-1:0]  in_vol;

  assign in_kind  = s_axis_tuser;
  assign in_seq   = s_axis_tdata[31:0];
  assign in_ttime = s_axis_tdata[71:32];
  assign in_now   = s_axis_tdata[111:72];
  assign in_price = s_axis_tdata[143:112];
  assign in_vol   = s_axis_tdata[159:144];

  // Control and working registers.
  state_e            state_q, state_d;
  logic [31:0]       last_seq_q, last_seq_d;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [CNT_W-1:0]  k_q, k_d;
  logic [CNT_W-1:0]  cb_q, cb_d, cs_q, cs_d;
  logic [CNT_W+15:0] vsum_q, vsum_d;
  rec_t              new_q, new_d;
  logic [TIME_W-1:0] now_q, now_d;
  logic [31:0]       price_q, price_d;
  logic [1:0]        side_q, side_d;
  logic [11:0]       bsec_q, bsec_d;
  logic [8:0]        ssec_q, ssec_d;
  logic [21:0]       bwin_q, bwin_d;
  logic [18:0]       swin_q, swin_d;
  logic [CNT_W+19:0] lhs_q, lhs_d;
  logic [CNT_W+15:0] rhs1_q, rhs1_d;
  logic [CNT_W+24:0] rhs_q, rhs_d;
  logic [19:0]       rb_q, rb_d, rs_q, rs_d;
  logic [23:0]       avg_q, avg_d;
  logic              o_valid_q, o_valid_d;
  logic [127:0]      o_data_q, o_data_d;
  logic [1:0]        o_user_q, o_user_d;

  // Chain of history cells; the oldest record sits in the last cell.
  logic   rotate;
  logic   replace;
  rec_t   feed;
  rec_t   tap;
  rec_t   cell_out [HISTORY_DEPTH];

  assign tap  = cell_out[HISTORY_DEPTH-1];
  assign feed = replace ? new_q : tap;

  for (genvar g = 0; g < HISTORY_DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      wtrs_cell u_cell (
        .clk_i  (clk_i),
        .shift_i(rotate),
        .rec_i  (feed),
        .rec_o  (cell_out[g])
      );
    end else begin : g_next
      wtrs_cell u_cell (
        .clk_i  (clk_i),
        .shift_i(rotate),
        .rec_i  (cell_out[g-1]),
        .rec_o  (cell_out[g])
      );
    end
  end

  // Shared divider.
  logic             div_start;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic             div_busy;
  logic             div_done;
  logic [NUM_W-1:0] div_quo;

  wtrs_div #(
    .NUM_W(NUM_W),
    .DEN_W(DEN_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .busy_o (div_busy),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // Age of the record at the far end and of the record being counted.
  logic [TIME_W:0] tap_diff;
  logic [TIME_W:0] cur_diff;
  logic            too_old;
  logic            in_base;
  logic            in_short;
  logic            counted;
  rec_t            cur;
  logic [19:0]     quo_sat;
  logic [8:0]      swc;
  logic            spike;

  assign cur      = replace ? new_q : tap;
  assign tap_diff = {1'b0, now_q} - {1'b0, tap.t};
  assign cur_diff = {1'b0, now_q} - {1'b0, cur.t};
  assign too_old  = !tap_diff[TIME_W] && (tap_diff[TIME_W-1:0] > MAX_AGE_MS);
  assign in_base  = !cur_diff[TIME_W] && (cur_diff[TIME_W-1:0] <= TIME_W'(bwin_q));
  assign in_short = !cur_diff[TIME_W] && (cur_diff[TIME_W-1:0] <= TIME_W'(swin_q));
  assign quo_sat  = (|div_quo[NUM_W-1:20]) ? 20'hFFFFF : div_quo[19:0];
  assign swc      = (32'(cs_q) > 32'd511) ? 9'd511 : 9'(cs_q);
  assign spike    = (cb_q != '0) && ((CNT_W+25)'(lhs_q) > rhs_q);

  // Sequencer: retire, store, scan, then arithmetic.
  always_comb begin
    state_d   = state_q;
    last_seq_d = last_seq_q;
    fill_d    = fill_q;
    k_d       = k_q;
    cb_d      = cb_q;
    cs_d      = cs_q;
    vsum_d    = vsum_q;
    new_d     = new_q;
    now_d     = now_q;
    price_d   = price_q;
    side_d    = side_q;
    bsec_d    = bsec_q;
    ssec_d    = ssec_q;
    bwin_d    = bwin_q;
    swin_d    = swin_q;
    lhs_d     = lhs_q;
    rhs1_d    = rhs1_q;
    rhs_d     = rhs_q;
    rb_d      = rb_q;
    rs_d      = rs_q;
    avg_d     = avg_q;
    o_valid_d = o_valid_q;
    o_data_d  = o_data_q;
    o_user_d  = o_user_q;
    rotate    = 1'b0;
    replace   = 1'b0;
    counted   = 1'b0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    s_axis_tready = (state_q == S_IDLE);

    if (o_valid_q && m_axis_tready) begin
      o_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          if ((in_kind == KIND_ASK_LIFT || in_kind == KIND_BID_HIT) &&
              (in_seq > last_seq_q) && (in_vol >= min_size_q)) begin
            last_seq_d = in_seq;
            new_d.t    = in_ttime;
            new_d.v    = in_vol;
            now_d      = in_now;
            price_d    = in_price;
            side_d     = (in_kind == KIND_ASK_LIFT) ? SIDE_ASK : SIDE_BID;
            bsec_d     = 12'((base_min_q == 6'd0) ? 6'd1 : base_min_q) * 12'd60;
            ssec_d     = (short_sec_q < 9'd5) ? 9'd5 : short_sec_q;
            state_d    = S_RETIRE;
          end
        end
      end
      S_RETIRE: begin
        bwin_d = 22'(bsec_q) * 22'd1000;
        swin_d = 19'(ssec_q) * 19'd1000;
        k_d    = '0;
        cb_d   = '0;
        cs_d   = '0;
        vsum_d = '0;
        if (fill_q != '0 && too_old) begin
          rotate = 1'b1;
          fill_d = fill_q - 1'b1;
        end else if (fill_q == DEPTH_C) begin
          state_d = S_STORE;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_STORE: begin
        // Full history: the new record takes the oldest one's place.
        rotate  = 1'b1;
        replace = 1'b1;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        rotate  = 1'b1;
        replace = (k_q == fill_q);
        counted = (k_q < fill_q) || replace;
        if (counted && in_base) begin
          cb_d = cb_q + 1'b1;
        end
        if (counted && in_short) begin
          cs_d   = cs_q + 1'b1;
          vsum_d = vsum_q + (CNT_W+16)'(cur.v);
        end
        k_d = k_q + 1'b1;
        if (k_q == CNT_W'(HISTORY_DEPTH - 1)) begin
          if (fill_q != DEPTH_C) begin
            fill_d = fill_q + 1'b1;
          end
          state_d = S_MUL1;
        end
      end
      S_MUL1: begin
        lhs_d  = {(CNT_W+12)'(cs_q) * (CNT_W+12)'(bsec_q), 8'd0};
        rhs1_d = (CNT_W+16)'(cb_q) * (CNT_W+16)'(mult_q);
        state_d = S_MUL2;
      end
      S_MUL2: begin
        rhs_d   = (CNT_W+25)'(rhs1_q) * (CNT_W+25)'(ssec_q);
        state_d = S_DIVB;
      end
      S_DIVB: begin
        div_start = 1'b1;
        div_num   = NUM_W'(cb_q) * NUM_W'(RATE_SCALE);
        div_den   = DEN_W'(bsec_q);
        state_d   = S_WAITB;
      end
      S_WAITB: begin
        if (div_done) begin
          rb_d    = quo_sat;
          state_d = S_DIVS;
        end
      end
      S_DIVS: begin
        div_start = 1'b1;
        div_num   = NUM_W'(cs_q) * NUM_W'(RATE_SCALE);
        div_den   = DEN_W'(ssec_q);
        state_d   = S_WAITS;
      end
      S_WAITS: begin
        if (div_done) begin
          rs_d    = quo_sat;
          state_d = S_DIVA;
        end
      end
      S_DIVA: begin
        if (cs_q == '0) begin
          avg_d   = '0;
          state_d = S_DONE;
        end else begin
          div_start = 1'b1;
          div_num   = {vsum_q, 8'd0};
          div_den   = DEN_W'(cs_q);
          state_d   = S_WAITA;
        end
      end
      S_WAITA: begin
        if (div_done) begin
          avg_d   = div_quo[23:0];
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!o_valid_q || m_axis_tready) begin
          o_valid_d = 1'b1;
          o_data_d  = {6'd0, spike, rs_q, rb_q, avg_q, swc, new_q.v, price_q};
          o_user_d  = side_q;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      last_seq_q <= '0;
      fill_q     <= '0;
      k_q        <= '0;
      o_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      last_seq_q <= last_seq_d;
      fill_q     <= fill_d;
      k_q        <= k_d;
      o_valid_q  <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cb_q     <= cb_d;
    cs_q     <= cs_d;
    vsum_q   <= vsum_d;
    new_q    <= new_d;
    now_q    <= now_d;
    price_q  <= price_d;
    side_q   <= side_d;
    bsec_q   <= bsec_d;
    ssec_q   <= ssec_d;
    bwin_q   <= bwin_d;
    swin_q   <= swin_d;
    lhs_q    <= lhs_d;
    rhs1_q   <= rhs1_d;
    rhs_q    <= rhs_d;
    rb_q     <= rb_d;
    rs_q     <= rs_d;
    avg_q    <= avg_d;
    o_data_q <= o_data_d;
    o_user_q <= o_user_d;
  end

  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tdata  = o_data_q;
  assign m_axis_tuser  = o_user_q;

  // The scan is about to hand over to the arithmetic.
  logic scan_end;

  assign scan_end = (state_q == S_SCAN) && (state_d != S_SCAN);

  // Checks on the sequencer.
  `include "windowed_trade_rate_spike_monitor_top_defines.svh"

  `WTRS_ASSERT(a_fill_bound, fill_q <= DEPTH_C, "history fill count beyond depth")
  `WTRS_NEVER(a_div_overlap, div_start && div_busy, "divider restarted while busy")
  `WTRS_ASSERT(a_scan_turn, scan_end |-> (k_q == LAST_K), "scan left before a full turn")

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Testbench for the windowed trade-rate spike monitor
// Drives trade prints as input beats and predicts result beats with a behavioural
// model of the history ring and both counting windows (one directed row has
// hand-set expectations). A short directed table covers the corner cases. Random
// prints under several register settings follow, with bursts of idling on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
  import wtrs_pkg::*;

  localparam logic [1:0] KIND_QUOTE = 2'd2;
  localparam logic [1:0] KIND_OTHER = 2'd3;
  localparam int         RING_DEPTH = 256;
  localparam logic [39:0] TIME_MAX  = 40'hFF_FFFF_FFFF;

  typedef struct packed {
    logic [31:0] price;
    logic [15:0] vol;
    logic [1:0]  side;
    logic [8:0]  short_cnt;
    logic [23:0] avg_q8;
    logic [19:0] rate_base;
    logic [19:0] rate_short;
    logic        spike;
  } rate_report_t;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] seq;
    logic [39:0] ttime;
    logic [39:0] now;
    logic [31:0] price;
    logic [15:0] vol;
    bit          typed;
  } print_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_idx_i = '0;
  logic [15:0]  cfg_data_i = '0;

  windowed_trade_rate_spike_monitor_top uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  // Shadow state of the monitor.
  logic [39:0] hist_time [RING_DEPTH];
  logic [15:0] hist_vol  [RING_DEPTH];
  int unsigned hist_head, hist_fill;
  logic [31:0] last_seq_seen;
  logic [5:0]  baseline_min = BASELINE_RST;
  logic [8:0]  short_sec    = SHORT_RST;
  logic [15:0] alert_mult   = MULT_RST;
  logic [15:0] min_size     = MIN_SIZE_RST;

  rate_report_t pending_reports[$];
  print_row_t   directed_rows[$];
  int           err_count = 0;
  int           reports_seen = 0;
  int           prints_sent = 0;
  bit           quiet = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #30_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Retire, store, then count both windows for one print.
  function automatic bit trade_window_stats(input print_row_t p, output rate_report_t r);
    longint unsigned bsec, ssec, cb, cs, vsum, rb, rs, age;
    int unsigned k;
    cb = 0; cs = 0; vsum = 0;
    r = '0;
    if (p.kind != KIND_ASK_LIFT && p.kind != KIND_BID_HIT) return 0;
    if (p.seq <= last_seq_seen) return 0;
    if (p.vol < min_size) return 0;
    while (hist_fill > 0 && p.now > hist_time[hist_head] &&
           p.now - hist_time[hist_head] > 40'd900000) begin
      hist_head = (hist_head + 1) % RING_DEPTH;
      hist_fill--;
    end
    if (hist_fill >= RING_DEPTH) begin
      hist_time[hist_head] = p.ttime;
      hist_vol[hist_head]  = p.vol;
      hist_head = (hist_head + 1) % RING_DEPTH;
    end else begin
      hist_time[(hist_head + hist_fill) % RING_DEPTH] = p.ttime;
      hist_vol[(hist_head + hist_fill) % RING_DEPTH]  = p.vol;
      hist_fill++;
    end
    last_seq_seen = p.seq;
    bsec = (baseline_min == 0 ? 1 : baseline_min) * 60;
    ssec = short_sec < 5 ? 5 : short_sec;
    for (int i = 0; i < hist_fill; i++) begin
      k = (hist_head + i) % RING_DEPTH;
      if (hist_time[k] <= p.now) begin
        age = p.now - hist_time[k];
        if (age <= bsec * 1000) cb++;
        if (age <= ssec * 1000) begin
          cs++;
          vsum += hist_vol[k];
        end
      end
    end
    rb = cb * 15360 / bsec;
    rs = cs * 15360 / ssec;
    r.price      = p.price;
    r.vol        = p.vol;
    r.side       = p.kind == KIND_ASK_LIFT ? SIDE_ASK : SIDE_BID;
    r.short_cnt  = 9'(cs > 511 ? 511 : cs);
    r.avg_q8     = 24'(cs > 0 ? (vsum * 256) / cs : 0);
    r.rate_base  = 20'(rb > 20'hFFFFF ? 20'hFFFFF : rb);
    r.rate_short = 20'(rs > 20'hFFFFF ? 20'hFFFFF : rs);
    r.spike      = cb > 0 && cs * 60 * bsec * 256 > cb * 60 * alert_mult * ssec;
    return 1;
  endfunction

  // Present one print and wait for its beat to be taken.
  task automatic send_print(input print_row_t p, input bit idle_ok);
    rate_report_t r;
    if (idle_ok && !quiet && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= p.kind;
    s_axis_tdata  <= {p.vol, p.price, p.now, p.ttime, p.seq};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    prints_sent++;
    if (trade_window_stats(p, r)) begin
      if (p.typed) begin
        r = '{price: 32'hFFFF_FFFF, vol: 16'hFFFF, side: SIDE_ASK, short_cnt: 9'd1,
              avg_q8: 24'd16776960, rate_base: 20'd85, rate_short: 20'd512, spike: 1'b1};
      end
      pending_reports.insert(pending_reports.size(), r);
    end
  endtask

  // Wait for the block to drain, then rewrite all four registers.
  task automatic write_settings(input logic [5:0] bm, input logic [8:0] ss,
                                input logic [15:0] am, input logic [15:0] ms);
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (700) @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= CFG_BASELINE; cfg_data_i <= 16'(bm);
    @(posedge clk_i);
    cfg_idx_i <= CFG_SHORT; cfg_data_i <= 16'(ss);
    @(posedge clk_i);
    cfg_idx_i <= CFG_MULT; cfg_data_i <= am;
    @(posedge clk_i);
    cfg_idx_i <= CFG_MIN_SIZE; cfg_data_i <= ms;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    baseline_min = bm; short_sec = ss; alert_mult = am; min_size = ms;
  endtask

  function automatic void add_row(input logic [1:0] kind, input logic [31:0] seq,
                                  input logic [39:0] tt, input logic [39:0] now,
                                  input logic [31:0] price, input logic [15:0] vol,
                                  input bit typed);
    print_row_t row;
    row = '{kind, seq, tt, now, price, vol, typed};
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  // Result side: random stall bursts, none in the closing part.
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (rst_ni && !quiet && $urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(1, 9) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each result beat with the oldest expectation.
  always @(posedge clk_i) begin
    rate_report_t want, got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{price: m_axis_tdata[31:0], vol: m_axis_tdata[47:32], side: m_axis_tuser,
              short_cnt: m_axis_tdata[56:48], avg_q8: m_axis_tdata[80:57],
              rate_base: m_axis_tdata[100:81], rate_short: m_axis_tdata[120:101],
              spike: m_axis_tdata[121]};
      reports_seen++;
      if (pending_reports.size() == 0) begin
        $error("unexpected result beat %h", m_axis_tdata);
        err_count++;
      end else begin
        want = pending_reports[0];
        pending_reports.delete(0);
        if (got.price != want.price) begin
          $error("out_price_ticks expected %0d got %0d", want.price, got.price); err_count++;
        end
        if (got.vol != want.vol) begin
          $error("out_volume expected %0d got %0d", want.vol, got.vol); err_count++;
        end
        if (got.side != want.side) begin
          $error("trade_side expected %b got %b", want.side, got.side); err_count++;
        end
        if (got.short_cnt != want.short_cnt) begin
          $error("short_window_count expected %0d got %0d", want.short_cnt, got.short_cnt);
          err_count++;
        end
        if (got.avg_q8 != want.avg_q8) begin
          $error("avg_size_q8 expected %0d got %0d", want.avg_q8, got.avg_q8); err_count++;
        end
        if (got.rate_base != want.rate_base) begin
          $error("rate_baseline_q8 expected %0d got %0d", want.rate_base, got.rate_base);
          err_count++;
        end
        if (got.rate_short != want.rate_short) begin
          $error("rate_short_q8 expected %0d got %0d", want.rate_short, got.rate_short);
          err_count++;
        end
        if (got.spike != want.spike) begin
          $error("spike_alert expected %0d got %0d", want.spike, got.spike); err_count++;
        end
      end
    end
  end

  // Stimulus.
  initial begin
    logic [5:0]  set_bm [6] = '{3, 1, 60, 0, 63, 3};
    logic [8:0]  set_ss [6] = '{30, 5, 300, 0, 511, 30};
    logic [15:0] set_am [6] = '{512, 0, 65535, 256, 384, 512};
    logic [15:0] set_ms [6] = '{1, 0, 1000, 1, 65535, 1};
    logic [31:0] seq_gen;
    logic [39:0] now_ms;
    print_row_t  p;
    int          pick;

    hist_head = 0; hist_fill = 0; last_seq_seen = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners: drop reasons, window edges, retirement, time extremes.
    add_row(KIND_ASK_LIFT, 0, 1000, 1000, 7, 10, 0);            // sequence zero after reset
    add_row(KIND_ASK_LIFT, 1, 1000, 1000, 32'hFFFF_FFFF, 16'hFFFF, 1);
    add_row(KIND_BID_HIT, 2, 1000, 1000, 0, 1, 0);
    add_row(KIND_QUOTE, 3, 2000, 2000, 5, 5, 0);
    add_row(KIND_OTHER, 3, 2000, 2000, 5, 5, 0);
    add_row(KIND_ASK_LIFT, 2, 2000, 2000, 5, 5, 0);             // repeated sequence
    add_row(KIND_BID_HIT, 3, 2000, 2000, 5, 0, 0);              // below minimum size
    add_row(KIND_ASK_LIFT, 4, 31000, 31000, 9, 5, 0);           // short window edge, inclusive
    add_row(KIND_BID_HIT, 5, 31001, 31001, 9, 6, 0);            // just past the edge
    add_row(KIND_ASK_LIFT, 6, TIME_MAX, 32000, 9, 7, 0);        // trade stamped in the future
    add_row(KIND_BID_HIT, 7, 0, 32000, 9, 8, 0);
    add_row(KIND_ASK_LIFT, 8, 932001, 932001, 9, 9, 0);         // retirement stops at future record
    add_row(KIND_BID_HIT, 9, 1832001, 1832001, 9, 9, 0);        // age exactly fifteen minutes
    add_row(KIND_ASK_LIFT, 10, TIME_MAX - 1, TIME_MAX, 9, 9, 0);
    add_row(KIND_BID_HIT, 11, 180000, 180000, 9, 9, 0);         // time steps back
    foreach (directed_rows[i]) send_print(directed_rows[i], 1'b0);

    seq_gen = 11;
    now_ms  = 40'd2_000_000;
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) write_settings(set_bm[ph], set_ss[ph], set_am[ph], set_ms[ph]);
      for (int n = 0; n < 140; n++) begin
        quiet = (ph == 5 && n >= 40);
        pick = $urandom_range(0, 99);
        p.typed = 1'b0;
        p.price = $urandom;
        if (pick < 8) begin
          // Quote or other print with every field random.
          p.kind  = $urandom_range(0, 1) ? KIND_QUOTE : KIND_OTHER;
          p.seq   = $urandom;
          p.ttime = 40'({$urandom, $urandom} & TIME_MAX);
          p.now   = 40'({$urandom, $urandom} & TIME_MAX);
          p.vol   = 16'($urandom);
        end else begin
          p.kind = $urandom_range(0, 1) ? KIND_BID_HIT : KIND_ASK_LIFT;
          if (pick < 13) begin
            p.seq = seq_gen - $urandom_range(0, 3);
          end else begin
            seq_gen = seq_gen + $urandom_range(1, 1 << 22);
            p.seq = seq_gen;
          end
          // No long time jumps in the first settings, so the history fills up
          // and wraps over its oldest records.
          now_ms = now_ms + ((ph >= 3 && $urandom_range(0, 49) == 0)
                             ? $urandom_range(0, 2_000_000) : $urandom_range(0, 1500));
          p.now = now_ms;
          case ($urandom_range(0, 19))
            0:       p.ttime = now_ms + $urandom_range(1, 5000);
            1:       p.ttime = 0;
            default: p.ttime = now_ms - $urandom_range(0, 400_000);
          endcase
          case ($urandom_range(0, 9))
            0:       p.vol = 16'hFFFF;
            1:       p.vol = 16'($urandom);
            default: p.vol = 16'($urandom_range(0, 3000));
          endcase
        end
        send_print(p, 1'b1);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (700) @(posedge clk_i);
    $display("Sent %0d prints over six register settings; checked %0d result beats.",
             prints_sent, reports_seen);
    if (err_count == 0 && pending_reports.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
